@@ hw/rtl/fmpf_pkg.sv @@
// Shared types and constants for the first-match packet filter.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package fmpf_pkg;

   localparam logic [1:0] CMD_RULE_WR  = 2'd0;
   localparam logic [1:0] CMD_SPAN_WR  = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;
   localparam logic [1:0] CMD_NONE     = 2'd3;

   localparam logic [1:0] PROTO_ALL  = 2'd0;
   localparam logic [1:0] FAM_ANY    = 2'd0;
   localparam logic [1:0] FAM_IPV4   = 2'd1;
   localparam logic [1:0] FAM_IPV6   = 2'd2;

   localparam logic CSR_ACTIVE_RULES  = 1'b0;
   localparam logic CSR_DEFAULT_ALLOW = 1'b1;

   localparam int ADDR_W = 128;

   typedef struct packed {
      logic        verdict;
      logic [1:0]  proto;
      logic [1:0]  family;
      logic [7:0]  prefix_len;
      logic        any_port;
      logic [15:0] span_first;
      logic [15:0] span_count;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } rule_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RULE_RD,
      ST_RULE_CHK,
      ST_SPAN_RD,
      ST_SPAN_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load_pkt;
      logic rule_next;
      logic span_start;
      logic span_next;
      logic set_hit;
      logic set_default;
      logic set_zero;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic rules_done;
      logic head_hit;
      logic any_port;
      logic span_done;
      logic span_hit;
   } ctl_status_type;

endpackage
`default_nettype wire

@@ hw/rtl/fmpf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
`default_nettype none
module fmpf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ hw/rtl/fmpf_datapath.sv @@
// Datapath of the filter: configuration registers, rule and span memories,
// packet latch, walk counters, match logic and the result register.
// Depends on fmpf_pkg and fmpf_ram.
`default_nettype none
module fmpf_datapath import fmpf_pkg::*; #(
   parameter int MAX_RULES = 64,
   parameter int MAX_SPANS = 256
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [1:0]     req_cmd,
   input  wire logic [7:0]     req_slot,
   input  wire logic           req_verdict,
   input  wire logic [1:0]     req_proto,
   input  wire logic [1:0]     req_family,
   input  wire logic [7:0]     req_prefix_len,
   input  wire logic [63:0]    req_addr_hi,
   input  wire logic [63:0]    req_addr_lo,
   input  wire logic           req_any_port,
   input  wire logic [15:0]    req_span_or_port_lo,
   input  wire logic [15:0]    req_span_or_port_hi,
   input  wire logic           csr_wr,
   input  wire logic           csr_index,
   input  wire logic [6:0]     csr_data,
   input  wire ctl_cmd_type    cmd,
   output ctl_status_type      status,
   output logic                rsp_allow,
   output logic [5:0]          rsp_hit_rule,
   output logic                rsp_by_default
);

   localparam int RAW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
   localparam int SAW  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
   localparam int RCW  = RAW + 1;
   localparam int CMPW = (RCW > 7) ? RCW : 7;
   localparam int RULE_W = $bits(rule_type);

   logic [6:0]  active_rules_ff;
   logic        default_allow_ff;

   logic [1:0]  pkt_proto_ff;
   logic [1:0]  pkt_family_ff;
   logic [63:0] pkt_hi_ff;
   logic [63:0] pkt_lo_ff;
   logic [15:0] pkt_port_ff;

   logic [RCW-1:0] rule_idx_ff, rule_idx_in;
   logic [16:0]    span_idx_ff, span_idx_in;
   logic [16:0]    span_end_ff, span_end_in;

   logic           res_allow_ff, res_allow_in;
   logic [5:0]     res_hit_ff, res_hit_in;
   logic           res_def_ff, res_def_in;

   rule_type        rule_wdata, rule_rd;
   logic [RULE_W-1:0] rule_rd_raw;
   logic [31:0]     span_rd;
   logic            rule_we, span_we;
   logic [16:0]     span_sum;
   logic [ADDR_W-1:0] pfx_mask;
   logic            pfx_ok;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_rules_ff  <= '0;
         default_allow_ff <= 1'b0;
      end else if (csr_wr) begin
         if (csr_index == CSR_ACTIVE_RULES) begin
            active_rules_ff <= csr_data;
         end else begin
            default_allow_ff <= csr_data[0];
         end
      end
   end

   // Table writes happen when the item is taken.
   assign rule_we = cmd.load_pkt && (req_cmd == CMD_RULE_WR)
                    && ({24'd0, req_slot} < 32'(MAX_RULES));
   assign span_we = cmd.load_pkt && (req_cmd == CMD_SPAN_WR)
                    && ({24'd0, req_slot} < 32'(MAX_SPANS));

   always_comb begin
      rule_wdata.verdict    = req_verdict;
      rule_wdata.proto      = req_proto;
      rule_wdata.family     = req_family;
      rule_wdata.prefix_len = req_prefix_len;
      rule_wdata.any_port   = req_any_port;
      rule_wdata.span_first = req_span_or_port_lo;
      rule_wdata.span_count = req_span_or_port_hi;
      rule_wdata.addr_hi    = req_addr_hi;
      rule_wdata.addr_lo    = req_addr_lo;
   end

   fmpf_ram #(.WIDTH(RULE_W), .DEPTH(MAX_RULES), .AW(RAW)) u_rule_ram (
      .clock      (clock),
      .wr_en      (rule_we),
      .wr_addr    (RAW'(req_slot)),
      .wr_data    (rule_wdata),
      .rd_addr    (rule_idx_ff[RAW-1:0]),
      .rd_data_ff (rule_rd_raw)
   );
   assign rule_rd = rule_type'(rule_rd_raw);

   fmpf_ram #(.WIDTH(32), .DEPTH(MAX_SPANS), .AW(SAW)) u_span_ram (
      .clock      (clock),
      .wr_en      (span_we),
      .wr_addr    (SAW'(req_slot)),
      .wr_data    ({req_span_or_port_hi, req_span_or_port_lo}),
      .rd_addr    (span_idx_ff[SAW-1:0]),
      .rd_data_ff (span_rd)
   );

   // Packet latch.
   always_ff @(posedge clock) begin
      if (cmd.load_pkt) begin
         pkt_proto_ff  <= req_proto;
         pkt_family_ff <= req_family;
         pkt_hi_ff     <= req_addr_hi;
         pkt_lo_ff     <= req_addr_lo;
         pkt_port_ff   <= req_span_or_port_lo;
      end
   end

   // Match logic. A shift by 128 or more leaves all ones in the mask.
   assign pfx_mask = ~({ADDR_W{1'b1}} >> rule_rd.prefix_len);
   assign pfx_ok   = ((({rule_rd.addr_hi, rule_rd.addr_lo} ^ {pkt_hi_ff, pkt_lo_ff})
                       & pfx_mask) == '0);
   assign span_sum = {1'b0, rule_rd.span_first} + {1'b0, rule_rd.span_count};

   always_comb begin
      status.rules_done = ({{(CMPW-RCW){1'b0}}, rule_idx_ff}
                           >= {{(CMPW-7){1'b0}}, active_rules_ff})
                          || ({{(CMPW-RCW){1'b0}}, rule_idx_ff} >= CMPW'(MAX_RULES));
      status.head_hit   = ((rule_rd.proto == PROTO_ALL) || (rule_rd.proto == pkt_proto_ff))
                          && ((rule_rd.family == FAM_ANY)
                              || ((rule_rd.family == pkt_family_ff)
                                  && ((rule_rd.family == FAM_IPV4)
                                      || (rule_rd.family == FAM_IPV6))
                                  && pfx_ok));
      status.any_port   = rule_rd.any_port;
      status.span_done  = (span_idx_ff >= span_end_ff);
      status.span_hit   = (pkt_port_ff >= span_rd[15:0]) && (pkt_port_ff <= span_rd[31:16]);
   end

   // Walk counters.
   always_comb begin
      rule_idx_in = rule_idx_ff;
      span_idx_in = span_idx_ff;
      span_end_in = span_end_ff;
      if (cmd.load_pkt) begin
         rule_idx_in = '0;
      end else if (cmd.rule_next) begin
         rule_idx_in = rule_idx_ff + RCW'(1);
      end
      if (cmd.span_start) begin
         span_idx_in = {1'b0, rule_rd.span_first};
         span_end_in = (span_sum > 17'(MAX_SPANS)) ? 17'(MAX_SPANS) : span_sum;
      end else if (cmd.span_next) begin
         span_idx_in = span_idx_ff + 17'd1;
      end
   end

   always_ff @(posedge clock) begin
      rule_idx_ff <= rule_idx_in;
      span_idx_ff <= span_idx_in;
      span_end_ff <= span_end_in;
   end

   // Result assembly and the output register.
   always_comb begin
      res_allow_in = res_allow_ff;
      res_hit_in   = res_hit_ff;
      res_def_in   = res_def_ff;
      if (cmd.set_zero) begin
         res_allow_in = 1'b0;
         res_hit_in   = '0;
         res_def_in   = 1'b0;
      end else if (cmd.set_hit) begin
         res_allow_in = rule_rd.verdict;
         res_hit_in   = 6'(rule_idx_ff);
         res_def_in   = 1'b0;
      end else if (cmd.set_default) begin
         res_allow_in = default_allow_ff;
         res_hit_in   = '0;
         res_def_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_allow_ff <= res_allow_in;
      res_hit_ff   <= res_hit_in;
      res_def_ff   <= res_def_in;
      if (cmd.out_load) begin
         rsp_allow      <= res_allow_ff;
         rsp_hit_rule   <= res_hit_ff;
         rsp_by_default <= res_def_ff;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/fmpf_ctrl.sv @@
// Controller state machine of the filter: sequences the rule walk and the span
// scan, and owns the input stall and the result valid. Depends on fmpf_pkg.
`default_nettype none
module fmpf_ctrl import fmpf_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [1:0]     req_cmd,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_cmd == CMD_CLASSIFY) ? ST_RULE_RD : ST_DONE;
            end
         end
         ST_RULE_RD:  state_in = status.rules_done ? ST_DONE : ST_RULE_CHK;
         ST_RULE_CHK: begin
            if (!status.head_hit) begin
               state_in = ST_RULE_RD;
            end else if (status.any_port) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SPAN_RD;
            end
         end
         ST_SPAN_RD:  state_in = status.span_done ? ST_RULE_RD : ST_SPAN_CHK;
         ST_SPAN_CHK: state_in = status.span_hit ? ST_DONE : ST_SPAN_RD;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_pkt = req_valid;
            cmd.set_zero = req_valid && (req_cmd != CMD_CLASSIFY);
         end
         ST_RULE_RD:  cmd.set_default = status.rules_done;
         ST_RULE_CHK: begin
            cmd.rule_next  = !status.head_hit;
            cmd.set_hit    = status.head_hit && status.any_port;
            cmd.span_start = status.head_hit && !status.any_port;
         end
         ST_SPAN_RD:  cmd.rule_next = status.span_done;
         ST_SPAN_CHK: begin
            cmd.set_hit   = status.span_hit;
            cmd.span_next = !status.span_hit;
         end
         ST_DONE:     cmd.out_load = out_free;
         default:     cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_valid_ff && rsp_stall |=> (state_ff == ST_DONE))
      else $error("result left while output still held");
   a_chk_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RULE_CHK) |-> ($past(state_ff) == ST_RULE_RD))
      else $error("rule check without a rule read");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result loaded without valid");
   a_span_from_rule: assert property (@(posedge clock) disable iff (reset)
      cmd.span_start |-> (state_ff == ST_RULE_CHK) && status.head_hit)
      else $error("span scan started without a head match");

endmodule
`default_nettype wire

@@ hw/rtl/first_match_packet_filter.sv @@
// Top level of the first-match packet filter.
// Joins fmpf_ctrl and fmpf_datapath; depends on fmpf_pkg.
//
// This block classifies packets against an ordered rule table. A transaction on
// the request channel either writes one rule (cmd 0), writes one destination-port
// span (cmd 1) or classifies a packet (cmd 2); every transaction gives exactly one
// response transaction, all zeros for writes. A classification walks the rules from
// index zero up to active_rules (capped at MAX_RULES); the first rule whose protocol,
// address family with source prefix, and port condition match gives the verdict and
// its index, otherwise default_allow applies and by_default is set. Rule and span
// tables are single-port-read memories, so each rule takes a read and a check state,
// and each span scanned for it another read and check; a write goes straight from
// idle to the done state, where its response is loaded. Table contents are undefined
// until written. The request channel is taken only while the block is idle, but a
// finished response may still sit in the output register meanwhile.
`default_nettype none
module first_match_packet_filter import fmpf_pkg::*; #(
   parameter int MAX_RULES = 64,
   parameter int MAX_SPANS = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_slot,
   input  wire logic        req_verdict,
   input  wire logic [1:0]  req_proto,
   input  wire logic [1:0]  req_family,
   input  wire logic [7:0]  req_prefix_len,
   input  wire logic [63:0] req_addr_hi,
   input  wire logic [63:0] req_addr_lo,
   input  wire logic        req_any_port,
   input  wire logic [15:0] req_span_or_port_lo,
   input  wire logic [15:0] req_span_or_port_hi,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_allow,
   output logic [5:0]       rsp_hit_rule,
   output logic             rsp_by_default,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Always taken, unchecked; user must do configuration writes only while idle.
   assign csr_ready = 1'b1;

   fmpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fmpf_datapath #(.MAX_RULES(MAX_RULES), .MAX_SPANS(MAX_SPANS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_cmd             (req_cmd),
      .req_slot            (req_slot),
      .req_verdict         (req_verdict),
      .req_proto           (req_proto),
      .req_family          (req_family),
      .req_prefix_len      (req_prefix_len),
      .req_addr_hi         (req_addr_hi),
      .req_addr_lo         (req_addr_lo),
      .req_any_port        (req_any_port),
      .req_span_or_port_lo (req_span_or_port_lo),
      .req_span_or_port_hi (req_span_or_port_hi),
      .csr_wr              (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .cmd                 (cmd),
      .status              (status),
      .rsp_allow           (rsp_allow),
      .rsp_hit_rule        (rsp_hit_rule),
      .rsp_by_default      (rsp_by_default)
   );

endmodule
`default_nettype wire

@@ bench/fmpf_checker.sv @@
// Checker for the first-match packet filter: watches the request, response and
// register channels, predicts each response and compares it. Depends on fmpf_pkg.
`default_nettype none
module fmpf_checker import fmpf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_slot,
   input  wire logic        req_verdict,
   input  wire logic [1:0]  req_proto,
   input  wire logic [1:0]  req_family,
   input  wire logic [7:0]  req_prefix_len,
   input  wire logic [63:0] req_addr_hi,
   input  wire logic [63:0] req_addr_lo,
   input  wire logic        req_any_port,
   input  wire logic [15:0] req_span_or_port_lo,
   input  wire logic [15:0] req_span_or_port_hi,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_allow,
   input  wire logic [5:0]  rsp_hit_rule,
   input  wire logic        rsp_by_default,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [6:0]  csr_data,
   output int               fail_count,
   output int               pending
);

   localparam int RULE_DEPTH = 64;
   localparam int SPAN_DEPTH = 256;

   typedef struct packed {
      logic       allow;
      logic [5:0] hit_rule;
      logic       by_default;
   } verdict_type;

   rule_type    rule_store[RULE_DEPTH];
   logic [31:0] span_store[SPAN_DEPTH];
   logic [6:0]  active_rules;
   logic        default_allow;
   verdict_type verdict_q[$];
   int          errors;

   // Walks the rules in order; the first one whose protocol, source prefix and
   // port condition all hold decides, else the default verdict applies.
   function automatic verdict_type classify_packet(logic [1:0] proto, logic [1:0] fam,
                                                   logic [127:0] addr, logic [15:0] port);
      verdict_type  res;
      rule_type     ru;
      logic [127:0] mask;
      int           walk;
      int           plen;
      int           stop;
      bit           hit;
      res = '{allow: default_allow, hit_rule: 6'd0, by_default: 1'b1};
      walk = (active_rules > RULE_DEPTH) ? RULE_DEPTH : active_rules;
      for (int r = 0; r < walk; r++) begin
         ru = rule_store[r];
         if (ru.proto != PROTO_ALL && ru.proto != proto) continue;
         if (ru.family != FAM_ANY) begin
            if (ru.family != fam) continue;
            if (ru.family != FAM_IPV4 && ru.family != FAM_IPV6) continue;
            plen = (ru.prefix_len > 128) ? 128 : ru.prefix_len;
            mask = (plen == 0) ? '0 : ~128'd0 << (128 - plen);
            if ((({ru.addr_hi, ru.addr_lo} ^ addr) & mask) != '0) continue;
         end
         hit = ru.any_port;
         stop = int'(ru.span_first) + int'(ru.span_count);
         if (stop > SPAN_DEPTH) stop = SPAN_DEPTH;
         for (int s = ru.span_first; s < stop && !hit; s++) begin
            if (span_store[s][15:0] <= port && port <= span_store[s][31:16]) hit = 1'b1;
         end
         if (hit) begin
            res = '{allow: ru.verdict, hit_rule: 6'(r), by_default: 1'b0};
            return res;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         active_rules  = '0;
         default_allow = 1'b0;
         verdict_q.delete();
         errors = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $error("response transaction with no expected result");
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_allow !== want.allow) begin
                  $error("allow: expected %0d, got %0d", want.allow, rsp_allow);
                  errors++;
               end
               if (rsp_hit_rule !== want.hit_rule) begin
                  $error("hit_rule: expected %0d, got %0d", want.hit_rule, rsp_hit_rule);
                  errors++;
               end
               if (rsp_by_default !== want.by_default) begin
                  $error("by_default: expected %0d, got %0d", want.by_default,
                         rsp_by_default);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ACTIVE_RULES) active_rules = csr_data;
            else default_allow = csr_data[0];
         end
         if (req_valid && !req_stall) begin
            want = '0;
            case (req_cmd)
               CMD_RULE_WR: begin
                  if (req_slot < RULE_DEPTH)
                     rule_store[req_slot] = '{verdict: req_verdict, proto: req_proto,
                        family: req_family, prefix_len: req_prefix_len,
                        any_port: req_any_port, span_first: req_span_or_port_lo,
                        span_count: req_span_or_port_hi, addr_hi: req_addr_hi,
                        addr_lo: req_addr_lo};
               end
               CMD_SPAN_WR: begin
                  span_store[req_slot] = {req_span_or_port_hi, req_span_or_port_lo};
               end
               CMD_CLASSIFY: begin
                  want = classify_packet(req_proto, req_family, {req_addr_hi, req_addr_lo},
                                         req_span_or_port_lo);
               end
               default: ;
            endcase
            verdict_q.push_back(want);
         end
      end
      fail_count <= errors;
      pending    <= verdict_q.size();
   end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// Testbench top for the first-match packet filter: drives request and register
// transactions, applies response stalls and gives the verdict. Depends on fmpf_pkg,
// fmpf_checker and first_match_packet_filter.
`default_nettype none
module tb import fmpf_pkg::*;;

   // The slowest legal classification walks 64 rules, each scanning the whole span
   // table with no handshake meanwhile; the limit lies above that walk.
   localparam int WATCHDOG_LIMIT = 150000;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  slot;
      logic        verdict;
      logic [1:0]  proto;
      logic [1:0]  family;
      logic [7:0]  prefix_len;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        any_port;
      logic [15:0] port_lo;
      logic [15:0] port_hi;
   } filter_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_cmd = CMD_NONE;
   logic [7:0]  req_slot = '0;
   logic        req_verdict = 1'b0;
   logic [1:0]  req_proto = '0;
   logic [1:0]  req_family = '0;
   logic [7:0]  req_prefix_len = '0;
   logic [63:0] req_addr_hi = '0;
   logic [63:0] req_addr_lo = '0;
   logic        req_any_port = 1'b0;
   logic [15:0] req_span_or_port_lo = '0;
   logic [15:0] req_span_or_port_hi = '0;
   logic        rsp_stall = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_index = CSR_ACTIVE_RULES;
   logic [6:0]  csr_data = '0;
   wire logic   req_stall;
   wire logic   rsp_valid;
   wire logic   rsp_allow;
   wire logic [5:0] rsp_hit_rule;
   wire logic   rsp_by_default;
   wire logic   csr_ready;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int stall_left = 0;
   bit calm = 1'b0;

   // Small pools of addresses and ports, shared by rules, spans and packets so
   // that classifications hit rules at every depth instead of mostly falling
   // through to the default.
   logic [63:0] pool_hi[4];
   logic [63:0] pool_lo[4];
   logic [15:0] pool_port[8];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   first_match_packet_filter i_dut (.*);

   fmpf_checker i_checker (.*);

   // The response side stalls in short random bursts unless the run is calm.
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The watchdog counts cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("first_match_packet_filter test failed");
         $finish;
      end
   end

   // Presents one request and holds it until it is taken. Valid stays high into
   // the next request unless a random gap follows, which only happens when not calm.
   task automatic send(input filter_req_type it);
      req_cmd             <= it.cmd;
      req_slot            <= it.slot;
      req_verdict         <= it.verdict;
      req_proto           <= it.proto;
      req_family          <= it.family;
      req_prefix_len      <= it.prefix_len;
      req_addr_hi         <= it.addr_hi;
      req_addr_lo         <= it.addr_lo;
      req_any_port        <= it.any_port;
      req_span_or_port_lo <= it.port_lo;
      req_span_or_port_hi <= it.port_hi;
      req_valid           <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected response has arrived, so the
   // registers can be rewritten while the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers back to back; valid stays high between the two.
   task automatic configure(input logic [6:0] rules, input logic dflt);
      csr_valid <= 1'b1;
      csr_index <= CSR_ACTIVE_RULES;
      csr_data  <= rules;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_DEFAULT_ALLOW;
      csr_data  <= {6'd0, dflt};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic filter_req_type noise_item();
      filter_req_type it;
      it = '{cmd: 2'($urandom), slot: 8'($urandom), verdict: 1'($urandom),
             proto: 2'($urandom), family: 2'($urandom), prefix_len: 8'($urandom),
             addr_hi: {$urandom, $urandom}, addr_lo: {$urandom, $urandom},
             any_port: 1'($urandom), port_lo: 16'($urandom), port_hi: 16'($urandom)};
      return it;
   endfunction

   function automatic filter_req_type rule_item(input logic [7:0] slot);
      filter_req_type it;
      int p;
      it = noise_item();
      p = $urandom_range(0, 3);
      it.cmd = CMD_RULE_WR;
      it.slot = slot;
      it.proto = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      it.family = ($urandom_range(0, 14) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
         0: it.prefix_len = 8'd0;
         1: it.prefix_len = 8'd128;
         2: it.prefix_len = 8'($urandom_range(129, 255));
         default: it.prefix_len = 8'($urandom_range(1, 127));
      endcase
      it.addr_hi = pool_hi[p];
      it.addr_lo = pool_lo[p];
      it.any_port = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 19) == 0) begin
         it.port_lo = 16'($urandom);
         it.port_hi = 16'($urandom_range(0, 300));
      end else begin
         it.port_lo = 16'($urandom_range(0, 255));
         it.port_hi = 16'($urandom_range(0, 6));
      end
      return it;
   endfunction

   function automatic filter_req_type span_item(input logic [7:0] slot);
      filter_req_type it;
      it = noise_item();
      it.cmd = CMD_SPAN_WR;
      it.slot = slot;
      if ($urandom_range(0, 7) != 0) begin
         it.port_lo = pool_port[$urandom_range(0, 7)] - 16'($urandom_range(0, 40));
         it.port_hi = it.port_lo + 16'($urandom_range(0, 120));
      end
      return it;
   endfunction

   function automatic filter_req_type packet_item();
      filter_req_type it;
      logic [63:0] flip;
      int p;
      it = noise_item();
      p = $urandom_range(0, 3);
      flip = {$urandom, $urandom} >> $urandom_range(0, 64);
      it.cmd = CMD_CLASSIFY;
      it.proto = 2'($urandom_range(1, 3));
      it.family = ($urandom_range(0, 14) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
      it.addr_hi = pool_hi[p];
      it.addr_lo = pool_lo[p];
      if ($urandom_range(0, 1) == 0) it.addr_lo = it.addr_lo ^ flip;
      else it.addr_hi = it.addr_hi ^ (flip >> $urandom_range(0, 63));
      if ($urandom_range(0, 5) != 0)
         it.port_lo = pool_port[$urandom_range(0, 7)] + 16'($urandom_range(0, 60)) - 16'd20;
      return it;
   endfunction

   function automatic filter_req_type mixed_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 14) return rule_item(($urandom_range(0, 9) == 0) ? 8'($urandom) :
                                      8'($urandom_range(0, 63)));
      if (pick < 24) return span_item(8'($urandom));
      if (pick < 28) return noise_item();
      return packet_item();
   endfunction

   initial begin
      filter_req_type it;
      logic [6:0] rules;
      int phases;

      foreach (pool_hi[i]) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      foreach (pool_port[i]) pool_port[i] = 16'($urandom_range(41, 65400));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill both tables first so that no classification ever reads an entry
      // whose content is still undefined.
      for (int s = 0; s < 256; s++) send(span_item(8'(s)));
      for (int r = 0; r < 64; r++) send(rule_item(8'(r)));
      drain();
      configure(7'd64, 1'b1);

      // Directed part. An unknown command answers zeros and changes nothing.
      it = noise_item();
      it.cmd = CMD_NONE;
      it.addr_hi = '1;
      it.addr_lo = '1;
      send(it);
      // A rule write beyond the table is ignored.
      it = rule_item(8'd255);
      it.proto = PROTO_ALL;
      it.family = FAM_ANY;
      it.any_port = 1'b1;
      send(it);
      // Rule zero: IPv6 with a prefix length past 128, so all 128 bits compare.
      it = rule_item(8'd0);
      it.proto = PROTO_ALL;
      it.family = FAM_IPV6;
      it.prefix_len = 8'd255;
      it.any_port = 1'b1;
      send(it);
      it = packet_item();
      it.family = FAM_IPV6;
      it.addr_hi = pool_hi[0];
      it.addr_lo = pool_lo[0];
      send(it);
      it.addr_lo = it.addr_lo ^ 64'd1;
      send(it);
      // Rule one has an unknown family and can never match.
      it = rule_item(8'd1);
      it.proto = PROTO_ALL;
      it.family = 2'd3;
      it.any_port = 1'b1;
      send(it);
      // Rules two and three point at spans partly or wholly beyond the table.
      it = rule_item(8'd2);
      it.proto = PROTO_ALL;
      it.family = FAM_ANY;
      it.any_port = 1'b0;
      it.port_lo = 16'd250;
      it.port_hi = 16'd20;
      send(it);
      it = rule_item(8'd3);
      it.proto = PROTO_ALL;
      it.family = FAM_ANY;
      it.any_port = 1'b0;
      it.port_lo = 16'hffff;
      it.port_hi = 16'hffff;
      send(it);
      // A span covering every port in the last table slot.
      it = span_item(8'd255);
      it.port_lo = 16'd0;
      it.port_hi = 16'hffff;
      send(it);
      // The last rule catches everything and denies.
      it = rule_item(8'd63);
      it.proto = PROTO_ALL;
      it.family = FAM_ANY;
      it.any_port = 1'b1;
      it.verdict = 1'b0;
      send(it);
      for (int k = 0; k < 4; k++) begin
         it = packet_item();
         it.proto = 2'(k % 3 + 1);
         it.family = 2'(k % 2 + 1);
         it.addr_hi = (k < 2) ? '0 : '1;
         it.addr_lo = (k < 2) ? '0 : '1;
         it.port_lo = (k % 2 == 0) ? 16'd0 : 16'hffff;
         send(it);
      end
      drain();
      // A rule count above the table size walks only the table.
      configure(7'd127, 1'b0);
      for (int k = 0; k < 4; k++) send(packet_item());
      drain();

      // Random part: phases of mixed traffic, each under its own register
      // setting. Every drain makes the sender wait for all outstanding responses.
      phases = 13;
      for (int ph = 0; ph < phases; ph++) begin
         case (ph)
            0: configure(7'd0, 1'b0);
            1: configure(7'd64, 1'b1);
            2: configure(7'd127, 1'b0);
            3: configure(7'd1, 1'b1);
            default: begin
               rules = ($urandom_range(0, 4) == 0) ? 7'd64 : 7'($urandom_range(0, 24));
               configure(rules, 1'($urandom));
            end
         endcase
         calm = (ph == phases - 1) || ($urandom_range(0, 4) == 0);
         repeat (80) send(mixed_item());
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("first_match_packet_filter test passed");
      end else begin
         $display("first_match_packet_filter test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
